[rtl/iopaf_pkg.sv]
// iopaf_pkg: opcodes, status codes, entry kinds and the table entry layout
// for the io port access filter; depends on nothing
`default_nettype none

package iopaf_pkg;

    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;
    localparam int WORD_W   = 32;
    localparam int SLOT_W   = 4;
    localparam int COUNT_W  = 16;
    localparam int CFG_W    = 5;

    localparam logic [OP_W-1:0] OP_READ   = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE  = 2'd1;
    localparam logic [OP_W-1:0] OP_LOAD   = 2'd2;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
    localparam logic [STATUS_W-1:0] ST_PERM    = 2'd2;

    localparam logic KIND_RANGE      = 1'b0;
    localparam logic KIND_RESTRICTED = 1'b1;

    localparam logic [1:0]        ALIGN_MASK = 2'b11;
    localparam logic [WORD_W-1:0] ALL_ONES   = '1;

    typedef struct packed {
        logic               kind;
        logic [WORD_W-1:0]  address;
        logic [WORD_W-1:0]  mask;
        logic [COUNT_W-1:0] count;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

`default_nettype wire

[rtl/iopaf_ram.sv]
// iopaf_ram: generic single-write, single-read ram with registered read data
// standalone, no package dependencies
`default_nettype none

module iopaf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[rtl/io_port_access_filter.sv]
// io_port_access_filter: top level, binary search of a sorted port table held
// in one iopaf_ram instance; depends on iopaf_pkg and iopaf_ram
`default_nettype none

// One item is handled at a time. A load, a misaligned access or the unused
// opcode goes from acceptance straight to the result state; a read or write
// first makes binary search probes in the wait state, at most
// ceil(log2(min(entries_in_use, TABLE_DEPTH) + 1)) probes (five for a full
// sixteen-entry table), one table ram read per probe. The result sits in an
// output register, so the next item is accepted while it waits. Table entries
// must be loaded before a search reaches them.
module io_port_access_filter #(
    parameter int TABLE_DEPTH = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_wr_en,
    input  wire logic [iopaf_pkg::CFG_W-1:0]       i_cfg_wr_data,
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire logic [iopaf_pkg::OP_W-1:0]        i_op,
    input  wire logic [iopaf_pkg::WORD_W-1:0]      i_port_address,
    input  wire logic [iopaf_pkg::WORD_W-1:0]      i_write_value,
    input  wire logic [iopaf_pkg::WORD_W-1:0]      i_port_current,
    input  wire logic [iopaf_pkg::SLOT_W-1:0]      i_slot,
    input  wire logic                              i_slot_kind,
    input  wire logic [iopaf_pkg::WORD_W-1:0]      i_slot_start,
    input  wire logic [iopaf_pkg::WORD_W-1:0]      i_slot_bits,
    input  wire logic [iopaf_pkg::COUNT_W-1:0]     i_slot_words,
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output logic [iopaf_pkg::STATUS_W-1:0]         o_status,
    output logic [iopaf_pkg::WORD_W-1:0]           o_read_data,
    output logic                                   o_write_enable,
    output logic [iopaf_pkg::WORD_W-1:0]           o_write_data
);

    import iopaf_pkg::*;

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_WAIT   = 3'b010,
        S_RESULT = 3'b100
    } t_state;

    t_state r_state, n_state;

    logic [CFG_W-1:0] r_entries_in_use;

    logic [CW-1:0] r_lo, n_lo;
    logic [CW-1:0] r_hi, n_hi;
    logic [CW-1:0] r_mid, n_mid;
    logic [WORD_W-1:0] r_mask, n_mask;
    logic r_invalid, n_invalid;

    logic [OP_W-1:0]   r_op;
    logic [WORD_W-1:0] r_port;
    logic [WORD_W-1:0] r_wval;
    logic [WORD_W-1:0] r_cur;

    logic                r_out_valid;
    logic [STATUS_W-1:0] r_status;
    logic [WORD_W-1:0]   r_read_data;
    logic                r_write_enable;
    logic [WORD_W-1:0]   r_write_data;

    logic          accept;
    logic          out_load;
    logic [CW-1:0] hi_sat;
    logic [CW:0]   mid_sum;
    logic          slot_ok;
    logic          ram_we;
    t_entry        ram_wdata;
    t_entry        ram_rdata;
    logic [WORD_W:0] e_start;
    logic [WORD_W:0] e_end;
    logic [WORD_W:0] e_port;
    logic          e_hit;

    assign accept   = i_valid && o_ready;
    assign o_ready  = (r_state == S_IDLE);
    assign out_load = (r_state == S_RESULT) && (!r_out_valid || i_ready);

    assign hi_sat = (32'(r_entries_in_use) > 32'(TABLE_DEPTH)) ?
                    CW'(TABLE_DEPTH) : CW'(r_entries_in_use);
    assign slot_ok = 32'(i_slot) < 32'(TABLE_DEPTH);

    assign ram_we            = accept && (i_op == OP_LOAD) && slot_ok;
    assign ram_wdata.kind    = i_slot_kind;
    assign ram_wdata.address = i_slot_start;
    assign ram_wdata.mask    = i_slot_bits;
    assign ram_wdata.count   = i_slot_words;

    // probe of the entry read in the previous cycle, ends in 33 bits
    assign e_start = {1'b0, ram_rdata.address};
    assign e_port  = {1'b0, r_port};
    assign e_end   = (ram_rdata.kind == KIND_RESTRICTED) ?
                     e_start + 33'd4 :
                     e_start + {15'b0, ram_rdata.count, 2'b00};
    assign e_hit   = (e_port >= e_start) && (e_port < e_end);

    always_comb begin
        n_state   = r_state;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_mask    = r_mask;
        n_invalid = r_invalid;
        mid_sum   = {1'b0, r_lo} + {1'b0, r_hi};
        case (r_state)
            S_IDLE: begin
                mid_sum = {1'b0, hi_sat};
                if (accept) begin
                    n_lo      = '0;
                    n_hi      = hi_sat;
                    n_mask    = '0;
                    n_invalid = 1'b0;
                    n_state   = S_RESULT;
                    if (i_op == OP_LOAD) begin
                        n_invalid = 1'b0;
                    end else if (i_op == OP_UNUSED ||
                                 (i_port_address[1:0] & ALIGN_MASK) != 2'b00) begin
                        n_invalid = 1'b1;
                    end else if (hi_sat != '0) begin
                        n_state = S_WAIT;
                    end
                end
            end
            S_WAIT: begin
                if (e_hit) begin
                    n_mask  = (ram_rdata.kind == KIND_RESTRICTED) ?
                              ram_rdata.mask : ALL_ONES;
                    n_state = S_RESULT;
                end else begin
                    if (e_start > e_port) begin
                        n_hi = r_mid;
                    end else begin
                        n_lo = r_mid + CW'(1);
                    end
                    mid_sum = {1'b0, n_lo} + {1'b0, n_hi};
                    if (mid_sum[CW:1] >= n_hi) begin
                        n_mask  = '0;
                        n_state = S_RESULT;
                    end
                end
            end
            S_RESULT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_mid = mid_sum[CW:1];
    end

    iopaf_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(TABLE_DEPTH)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(IW'(i_slot)),
        .i_wdata(ram_wdata),
        .i_raddr(n_mid[IW-1:0]),
        .o_rdata(ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_IDLE;
            r_entries_in_use <= '0;
            r_lo             <= '0;
            r_hi             <= '0;
            r_mid            <= '0;
            r_invalid        <= 1'b0;
            r_out_valid      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_lo      <= n_lo;
            r_hi      <= n_hi;
            r_mid     <= n_mid;
            r_invalid <= n_invalid;
            if (i_cfg_wr_en) begin
                r_entries_in_use <= i_cfg_wr_data;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mask <= n_mask;
        if (accept) begin
            r_op   <= i_op;
            r_port <= i_port_address;
            r_wval <= i_write_value;
            r_cur  <= i_port_current;
        end
        if (out_load) begin
            r_status       <= ST_OK;
            r_read_data    <= '0;
            r_write_enable <= 1'b0;
            r_write_data   <= '0;
            if (r_op == OP_LOAD) begin
                r_status <= ST_OK;
            end else if (r_invalid) begin
                r_status <= ST_INVALID;
            end else if (r_mask == '0) begin
                r_status <= ST_PERM;
            end else if (r_op == OP_READ) begin
                r_read_data <= r_cur & r_mask;
            end else begin
                r_write_enable <= 1'b1;
                r_write_data   <= (r_cur & ~r_mask) | (r_wval & r_mask);
            end
        end
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_status;
    assign o_read_data    = r_read_data;
    assign o_write_enable = r_write_enable;
    assign o_write_data   = r_write_data;

`ifndef ASSERT_OFF
    a_probe_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WAIT) |-> (r_mid < r_hi && r_lo <= r_mid))
        else $error("search probe outside window");

    a_window_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WAIT) |-> (32'(r_hi) <= 32'(TABLE_DEPTH)))
        else $error("search window beyond table");

    a_load_direct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_op == OP_LOAD) |=> (r_state == S_RESULT))
        else $error("load item did not go straight to result");

    a_error_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |->
        (o_read_data == '0 && !o_write_enable && o_write_data == '0))
        else $error("error result carries data");

    a_write_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_write_enable) |-> (o_status == ST_OK && o_read_data == '0))
        else $error("port write with bad status or read data");
`endif

endmodule

`default_nettype wire

[dv/testbench.sv]
`timescale 1ns / 1ps
// testbench: self-checking bench for io_port_access_filter, predicts every result
// from its own model of the sorted port table; depends on iopaf_pkg and the rtl

module testbench;
    import iopaf_pkg::*;

    localparam int DEPTH         = 16;
    localparam int HOLD_CYCLES   = 300;
    localparam int IDLE_LIMIT    = 4000;
    localparam int SETTLE_CYCLES = 20;
    localparam int REPORT_MAX    = 10;
    localparam int RX_OPEN       = 0;
    localparam int RX_RANDOM     = 1;
    localparam int RX_SLOW       = 2;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [WORD_W-1:0]  port_address;
        logic [WORD_W-1:0]  write_value;
        logic [WORD_W-1:0]  port_current;
        logic [SLOT_W-1:0]  slot;
        logic               slot_kind;
        logic [WORD_W-1:0]  slot_start;
        logic [WORD_W-1:0]  slot_bits;
        logic [COUNT_W-1:0] slot_words;
    } t_port_request;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [WORD_W-1:0]   read_data;
        logic                write_enable;
        logic [WORD_W-1:0]   write_data;
    } t_port_response;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_wr_en;
    logic [CFG_W-1:0]    i_cfg_wr_data;
    logic                i_valid;
    logic                o_ready;
    logic [OP_W-1:0]     i_op;
    logic [WORD_W-1:0]   i_port_address;
    logic [WORD_W-1:0]   i_write_value;
    logic [WORD_W-1:0]   i_port_current;
    logic [SLOT_W-1:0]   i_slot;
    logic                i_slot_kind;
    logic [WORD_W-1:0]   i_slot_start;
    logic [WORD_W-1:0]   i_slot_bits;
    logic [COUNT_W-1:0]  i_slot_words;
    logic                o_valid;
    logic                i_ready;
    logic [STATUS_W-1:0] o_status;
    logic [WORD_W-1:0]   o_read_data;
    logic                o_write_enable;
    logic [WORD_W-1:0]   o_write_data;

    t_entry         port_table [DEPTH];
    logic [CFG_W-1:0] model_in_use;
    t_port_response pending_responses [$];
    t_port_response observed;
    t_port_response awaited;
    int             fault_count;
    int             burst_left;
    bit             hold_request;

    io_port_access_filter #(
        .TABLE_DEPTH(DEPTH)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_op           (i_op),
        .i_port_address (i_port_address),
        .i_write_value  (i_write_value),
        .i_port_current (i_port_current),
        .i_slot         (i_slot),
        .i_slot_kind    (i_slot_kind),
        .i_slot_start   (i_slot_start),
        .i_slot_bits    (i_slot_bits),
        .i_slot_words   (i_slot_words),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_status       (o_status),
        .o_read_data    (o_read_data),
        .o_write_enable (o_write_enable),
        .o_write_data   (o_write_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [WORD_W-1:0] search_mask(logic [WORD_W-1:0] port);
        int lo;
        int hi;
        int mid;
        logic [WORD_W:0] first;
        logic [WORD_W:0] stop;
        logic [WORD_W:0] probe;
        probe = {1'b0, port};
        lo = 0;
        hi = (model_in_use > DEPTH) ? DEPTH : int'(model_in_use);
        mid = (lo + hi) / 2;
        while (mid < hi) begin
            first = {1'b0, port_table[mid].address};
            if (port_table[mid].kind == KIND_RESTRICTED) begin
                stop = first + 33'd4;
                if (probe >= first && probe < stop) return port_table[mid].mask;
            end else begin
                stop = first + {15'b0, port_table[mid].count, 2'b00};
                if (probe >= first && probe < stop) return ALL_ONES;
            end
            if (first > probe) hi = mid;
            else lo = mid + 1;
            mid = (lo + hi) / 2;
        end
        return '0;
    endfunction

    function automatic t_port_response apply_request(t_port_request r);
        t_port_response resp;
        logic [WORD_W-1:0] mask;
        resp = '0;
        resp.status = ST_OK;
        if (r.op == OP_LOAD) begin
            port_table[r.slot].kind    = r.slot_kind;
            port_table[r.slot].address = r.slot_start;
            port_table[r.slot].mask    = r.slot_bits;
            port_table[r.slot].count   = r.slot_words;
        end else if (r.op == OP_UNUSED || (r.port_address[1:0] & ALIGN_MASK) != 2'b00) begin
            resp.status = ST_INVALID;
        end else begin
            mask = search_mask(r.port_address);
            if (mask == '0) begin
                resp.status = ST_PERM;
            end else if (r.op == OP_READ) begin
                resp.read_data = r.port_current & mask;
            end else begin
                resp.write_enable = 1'b1;
                resp.write_data = (mask == ALL_ONES) ? r.write_value
                                : (r.port_current & ~mask) | (r.write_value & mask);
            end
        end
        return resp;
    endfunction

    function automatic t_port_request make_access(logic [OP_W-1:0] op,
                                                  logic [WORD_W-1:0] addr,
                                                  logic [WORD_W-1:0] wval,
                                                  logic [WORD_W-1:0] cur);
        t_port_request r;
        r.op           = op;
        r.port_address = addr;
        r.write_value  = wval;
        r.port_current = cur;
        r.slot         = $urandom_range(0, DEPTH - 1);
        r.slot_kind    = $urandom_range(0, 1);
        r.slot_start   = $urandom;
        r.slot_bits    = $urandom;
        r.slot_words   = $urandom;
        return r;
    endfunction

    function automatic t_port_request make_load(logic [SLOT_W-1:0] slot, logic kind,
                                                logic [WORD_W-1:0] start,
                                                logic [WORD_W-1:0] bits,
                                                logic [COUNT_W-1:0] words);
        t_port_request r;
        r.op           = OP_LOAD;
        r.port_address = $urandom;
        r.write_value  = $urandom;
        r.port_current = $urandom;
        r.slot         = slot;
        r.slot_kind    = kind;
        r.slot_start   = start;
        r.slot_bits    = bits;
        r.slot_words   = words;
        return r;
    endfunction

    function automatic logic [WORD_W-1:0] pick_port();
        int searched;
        int choice;
        int span;
        t_entry e;
        logic [WORD_W-1:0] addr;
        searched = (model_in_use > DEPTH) ? DEPTH : int'(model_in_use);
        choice = $urandom_range(0, 99);
        if (searched == 0) choice = $urandom_range(65, 99);
        e = port_table[$urandom_range(0, (searched == 0) ? 0 : searched - 1)];
        if (choice < 10 && e.kind == KIND_RANGE && e.count != 0) begin
            addr = e.address + 4 * (e.count - 1);
        end else if (choice < 50) begin
            span = (e.kind == KIND_RANGE && e.count != 0) ? int'(e.count) - 1 : 0;
            addr = e.address + 4 * $urandom_range(0, (span > 20) ? 20 : span);
        end else if (choice < 58) begin
            addr = e.address - 4;
        end else if (choice < 65) begin
            addr = e.address + ((e.kind == KIND_RANGE) ? {14'b0, e.count, 2'b00} : 32'd4);
        end else if (choice < 80) begin
            addr = $urandom & ~32'h3;
        end else if (choice < 90) begin
            addr = (e.address & ~32'h3) | $urandom_range(1, 3);
        end else begin
            addr = $urandom;
        end
        return addr;
    endfunction

    function automatic logic [WORD_W-1:0] pick_word();
        int choice;
        choice = $urandom_range(0, 9);
        if (choice == 0) return '0;
        if (choice == 1) return ALL_ONES;
        return $urandom;
    endfunction

    function automatic t_port_request random_request();
        int choice;
        choice = $urandom_range(0, 99);
        if (choice < 45) return make_access(OP_READ, pick_port(), pick_word(), pick_word());
        if (choice < 90) return make_access(OP_WRITE, pick_port(), pick_word(), pick_word());
        if (choice < 94) return make_access(OP_UNUSED, pick_port(), pick_word(), pick_word());
        // stray load with random content, may break the sort order
        return make_load($urandom_range(0, DEPTH - 1), $urandom_range(0, 1), $urandom,
                         $urandom, $urandom_range(0, 65535));
    endfunction

    task automatic drive_payload(t_port_request r);
        i_op           = r.op;
        i_port_address = r.port_address;
        i_write_value  = r.write_value;
        i_port_current = r.port_current;
        i_slot         = r.slot;
        i_slot_kind    = r.slot_kind;
        i_slot_start   = r.slot_start;
        i_slot_bits    = r.slot_bits;
        i_slot_words   = r.slot_words;
    endtask

    task automatic send_item(t_port_request r);
        int gap;
        @(negedge i_clk);
        i_valid = 1'b1;
        drive_payload(r);
        do @(posedge i_clk); while (!o_ready);
        pending_responses.push_back(apply_request(r));
        burst_left--;
        if (burst_left <= 0) begin
            gap = $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
            @(negedge i_clk);
            i_valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic wait_until_idle();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (pending_responses.size() != 0) @(negedge i_clk);
    endtask

    task automatic set_entries_in_use(int n);
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b1;
        i_cfg_wr_data = n[CFG_W-1:0];
        model_in_use  = n[CFG_W-1:0];
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b0;
    endtask

    task automatic load_sorted_table(bit near_top);
        logic [WORD_W:0]    next_addr;
        logic               kind;
        logic [WORD_W-1:0]  bits;
        logic [COUNT_W-1:0] words;
        int                 choice;
        next_addr = near_top ? 33'h0_FFFF_FC00 : 33'($urandom_range(0, 'h3FFF)) * 4;
        for (int i = 0; i < DEPTH; i++) begin
            kind = ($urandom_range(0, 2) == 0) ? KIND_RESTRICTED : KIND_RANGE;
            choice = $urandom_range(0, 19);
            bits = (choice == 0) ? '0 : (choice == 1) ? ALL_ONES : $urandom;
            choice = $urandom_range(0, 19);
            if (near_top) words = (i == DEPTH - 1) ? '1 : $urandom_range(1, 8);
            else if (choice == 0) words = '0;
            else if (choice == 1) words = '1;
            else if (choice <= 3) words = $urandom;
            else words = $urandom_range(1, 8);
            send_item(make_load(i, kind, next_addr[WORD_W-1:0], bits, words));
            next_addr = next_addr + ((kind == KIND_RESTRICTED) ? 33'd4 : {15'b0, words, 2'b00})
                      + 33'(4 * $urandom_range(0, 3));
        end
    endtask

    task automatic run_accesses(int n);
        repeat (n) send_item(random_request());
    endtask

    task automatic test_directed();
        wait_until_idle();
        set_entries_in_use(0);
        send_item(make_access(OP_READ, 32'h100, '0, ALL_ONES));
        send_item(make_load(0, KIND_RANGE, 32'h100, '0, 16'd4));
        send_item(make_load(1, KIND_RESTRICTED, 32'h200, 32'h0000_FF0F, '0));
        send_item(make_load(2, KIND_RESTRICTED, 32'h300, '0, 16'd1));
        send_item(make_load(3, KIND_RANGE, 32'hFFFF_FFF0, ALL_ONES, 16'hFFFF));
        send_item(make_access(OP_UNUSED, 32'h100, ALL_ONES, ALL_ONES));
        wait_until_idle();
        set_entries_in_use(4);
        send_item(make_access(OP_READ, 32'h100, '0, ALL_ONES));
        send_item(make_access(OP_WRITE, 32'h10C, ALL_ONES, '0));
        send_item(make_access(OP_READ, 32'h110, '0, ALL_ONES));
        send_item(make_access(OP_WRITE, 32'h200, ALL_ONES, '0));
        send_item(make_access(OP_READ, 32'h200, '0, ALL_ONES));
        send_item(make_access(OP_WRITE, 32'h200, '0, ALL_ONES));
        send_item(make_access(OP_READ, 32'h300, '0, ALL_ONES));
        // range running past the top of the address space
        send_item(make_access(OP_WRITE, 32'hFFFF_FFFC, '0, ALL_ONES));
        send_item(make_access(OP_READ, 32'hFFFF_FFEC, '0, ALL_ONES));
        send_item(make_access(OP_READ, 32'h101, ALL_ONES, ALL_ONES));
        send_item(make_access(OP_WRITE, 32'h102, ALL_ONES, ALL_ONES));
        send_item(make_access(OP_READ, 32'hFFFF_FFFF, ALL_ONES, ALL_ONES));
        send_item(make_access(OP_UNUSED, 32'h200, ALL_ONES, ALL_ONES));
        send_item(make_access(OP_READ, 32'h0, '0, '0));
        send_item(make_access(OP_WRITE, 32'h0FC, ALL_ONES, '0));
        send_item(make_load(1, KIND_RESTRICTED, 32'h200, ALL_ONES, '0));
        send_item(make_access(OP_WRITE, 32'h200, 32'hA5A5_5A5A, 32'h1234_5678));
        send_item(make_access(OP_READ, 32'h204, '0, ALL_ONES));
    endtask

    task automatic test_output_hold();
        wait_until_idle();
        set_entries_in_use(16);
        load_sorted_table(1'b0);
        hold_request = 1'b1;
        run_accesses(100);
    endtask

    task automatic test_random_tables();
        int in_use_steps [12] = '{16, 31, 1, 0, 17, 2, 16, 8, 5, 3, 12, 16};
        for (int i = 0; i < 12; i++) begin
            wait_until_idle();
            set_entries_in_use(in_use_steps[i]);
            load_sorted_table(i % 4 == 1);
            run_accesses(80);
        end
    endtask

    // receiver: stall pattern in random modes, plus one long hold on request
    initial begin
        int mode;
        int mode_left;
        i_ready = 1'b0;
        mode = RX_OPEN;
        mode_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                i_ready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_request = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode = $urandom_range(RX_OPEN, RX_SLOW);
                    mode_left = $urandom_range(10, 80);
                end
                mode_left--;
                case (mode)
                    RX_OPEN:   i_ready = 1'b1;
                    RX_RANDOM: i_ready = $urandom_range(0, 1);
                    default:   i_ready = ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            observed = {o_status, o_read_data, o_write_enable, o_write_data};
            if (pending_responses.size() == 0) begin
                fault_count++;
                if (fault_count <= REPORT_MAX)
                    $display("unexpected item: status %0d read %h wen %0b write %h",
                             observed.status, observed.read_data,
                             observed.write_enable, observed.write_data);
            end else begin
                awaited = pending_responses.pop_front();
                if (observed.status !== awaited.status
                        || observed.read_data !== awaited.read_data
                        || observed.write_enable !== awaited.write_enable
                        || observed.write_data !== awaited.write_data) begin
                    fault_count++;
                    if (fault_count <= REPORT_MAX)
                        $display("mismatch: expected status %0d read %h wen %0b write %h, %s",
                                 awaited.status, awaited.read_data, awaited.write_enable,
                                 awaited.write_data,
                                 $sformatf("got status %0d read %h wen %0b write %h",
                                           observed.status, observed.read_data,
                                           observed.write_enable, observed.write_data));
                end
            end
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles = 0;
            else idle_cycles++;
        end
        $display("Verification failed");
        $finish;
    end

    initial begin
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        drive_payload('0);
        fault_count   = 0;
        burst_left    = 1;
        hold_request  = 1'b0;
        model_in_use  = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_output_hold();
        test_random_tables();
        wait_until_idle();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (fault_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
